[design/mst_with_virtual_hub_cost_macros.svh]
// Assertion helpers used by the datapath.
`ifndef MST_WITH_VIRTUAL_HUB_COST_MACROS_SVH
`define MST_WITH_VIRTUAL_HUB_COST_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define MVH_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define MVH_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MVH_ASSERT_IMP(lbl, pre, post, msg)
`define MVH_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

[design/mvh_pkg.sv]
package mvh_pkg;
    // fixed field widths
    localparam int END_W      = 9;
    localparam int IN_COST_W  = 16;
    localparam int SUM_W      = 24;
    localparam int HUB_W      = 9;
    localparam int NODE_CFG_W = 9;
    localparam int RANK_W     = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUB_COST   = 1'd1;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_INIT,
        DP_SETUP,
        DP_SCAN,
        DP_PICK,
        DP_WCHK,
        DP_JOIN,
        DP_JOIN2,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic best_ok;
        logic walk_hit;
        logic walk_side;
        logic roots_eq;
        logic need_bump;
        logic out_free;
    } t_dp_status;
endpackage

[design/mvh_if.sv]
// input word channel
interface mvh_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [8:0] end_a;
    logic [8:0] end_b;
    logic [15:0] edge_cost;
    modport source (output valid, action, end_a, end_b, edge_cost, input ready);
    modport sink (input valid, action, end_a, end_b, edge_cost, output ready);
endinterface

// result word channel
interface mvh_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] total_cost;
    logic [8:0]  hub_edges_used;
    logic        overflow;
    modport source (output valid, total_cost, hub_edges_used, overflow, input ready);
    modport sink (input valid, total_cost, hub_edges_used, overflow, output ready);
endinterface

// configuration write channel
interface mvh_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/mvh_ram.sv]
module mvh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/mvh_ctrl.sv]
module mvh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_action,
    input  mvh_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output mvh_pkg::t_dp_cmd    o_cmd
);
    import mvh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SETUP, S_SCAN, S_PICK, S_WRD, S_WCHK, S_JOIN, S_JOIN2, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_dp_op w_op;

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        w_op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action) begin
                        w_op    = DP_START;
                        n_state = S_INIT;
                    end else begin
                        w_op = DP_LOAD;
                    end
                end
            end
            S_INIT: begin
                w_op = DP_INIT;
                if (i_status.init_done) n_state = S_SETUP;
            end
            S_SETUP: begin
                w_op    = DP_SETUP;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_op = DP_SCAN;
                if (i_status.scan_done) n_state = S_PICK;
            end
            S_PICK: begin
                w_op    = DP_PICK;
                n_state = i_status.best_ok ? S_WRD : S_FIN;
            end
            S_WRD: begin
                n_state = S_WCHK;
            end
            S_WCHK: begin
                w_op = DP_WCHK;
                if (!i_status.walk_hit || !i_status.walk_side) begin
                    n_state = S_WRD;
                end else if (i_status.roots_eq) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = S_JOIN;
                end
            end
            S_JOIN: begin
                w_op    = DP_JOIN;
                n_state = i_status.need_bump ? S_JOIN2 : S_SETUP;
            end
            S_JOIN2: begin
                w_op    = DP_JOIN2;
                n_state = S_SETUP;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    w_op    = DP_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = w_op;
endmodule

[design/mvh_dp.sv]
`include "mst_with_virtual_hub_cost_macros.svh"
module mvh_dp #(
    parameter int MAX_NODES = 256,
    parameter int MAX_ROADS = 1024,
    parameter int COST_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mvh_pkg::t_dp_cmd                    i_cmd,
    output mvh_pkg::t_dp_status                 o_status,
    input  logic [mvh_pkg::END_W-1:0]           i_end_a,
    input  logic [mvh_pkg::END_W-1:0]           i_end_b,
    input  logic [mvh_pkg::IN_COST_W-1:0]       i_edge_cost,
    input  logic                                i_cfg_valid,
    input  logic [mvh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mvh_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mvh_pkg::SUM_W-1:0]           o_total_cost,
    output logic [mvh_pkg::HUB_W-1:0]           o_hub_edges_used,
    output logic                                o_overflow
);
    import mvh_pkg::*;

    localparam int FW  = $clog2(MAX_ROADS + 1);
    localparam int EAW = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
    localparam int EW  = 2 * END_W + COST_BITS;
    localparam int KW  = COST_BITS + 2 * END_W;
    localparam int PAW = $clog2(MAX_NODES + 1);
    localparam int PW  = PAW + RANK_W;

    // configuration
    logic [NODE_CFG_W-1:0] r_node_count;
    logic [IN_COST_W-1:0]  r_hub_cost;
    // load side
    logic [FW-1:0]         r_fill;
    logic                  r_drop;
    // compute
    logic [END_W-1:0]      r_n;
    logic [PAW-1:0]        r_ic;
    logic [FW-1:0]         r_sa;
    logic                  r_rv;
    logic [KW-1:0]         r_last, r_best;
    logic                  r_have_last, r_best_ok;
    logic [PAW-1:0]        r_x, r_ra;
    logic [RANK_W-1:0]     r_rka, r_rkb;
    logic                  r_side;
    logic [SUM_W-1:0]      r_sum;
    logic [HUB_W-1:0]      r_hub;
    // result register
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_cost;
    logic [HUB_W-1:0]      r_out_hub;
    logic                  r_out_ovf;

    logic                  w_e_we;
    logic [EW-1:0]         w_e_rd;
    logic                  w_p_we;
    logic [PAW-1:0]        w_p_wa;
    logic [PW-1:0]         w_p_wd;
    logic [PW-1:0]         w_p_rd;
    logic [PAW-1:0]        w_p_par;
    logic [RANK_W-1:0]     w_p_rank;

    // edge store
    assign w_e_we = (i_cmd.op == DP_LOAD) && (32'(r_fill) < MAX_ROADS);

    mvh_ram #(.WIDTH(EW), .DEPTH(MAX_ROADS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (r_fill[EAW-1:0]),
        .i_wdata ({i_end_a, i_end_b, COST_BITS'(i_edge_cost)}),
        .i_raddr (r_sa[EAW-1:0]),
        .o_rdata (w_e_rd)
    );

    // parent and rank table
    assign w_p_par  = w_p_rd[PW-1:RANK_W];
    assign w_p_rank = w_p_rd[RANK_W-1:0];

    logic w_rank_gt;
    assign w_rank_gt = (r_rka > r_rkb);

    always_comb begin
        w_p_we = 1'b0;
        w_p_wa = r_ic;
        w_p_wd = {r_ic, RANK_W'(0)};
        case (i_cmd.op)
            DP_INIT: begin
                w_p_we = 1'b1;
            end
            DP_JOIN: begin
                w_p_we = 1'b1;
                if (w_rank_gt) begin
                    w_p_wa = r_x;
                    w_p_wd = {r_ra, r_rkb};
                end else begin
                    w_p_wa = r_ra;
                    w_p_wd = {r_x, r_rka};
                end
            end
            DP_JOIN2: begin
                w_p_we = 1'b1;
                w_p_wa = r_x;
                w_p_wd = {r_x, r_rkb + RANK_W'(1)};
            end
            default: w_p_we = 1'b0;
        endcase
    end

    mvh_ram #(.WIDTH(PW), .DEPTH(MAX_NODES + 1)) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_wa),
        .i_wdata (w_p_wd),
        .i_raddr (r_x),
        .o_rdata (w_p_rd)
    );

    // key fields
    logic [COST_BITS-1:0] w_hc, w_lc;
    logic [END_W-1:0]     w_la, w_lb;
    logic                 w_hub_ok;
    logic [END_W-1:0]     w_hub_b;
    logic [END_W-1:0]     w_n_clamp;

    assign w_hc = COST_BITS'(r_hub_cost);
    assign w_lc = r_last[KW-1 -: COST_BITS];
    assign w_la = r_last[2*END_W-1 -: END_W];
    assign w_lb = r_last[END_W-1:0];
    assign w_n_clamp = (32'(r_node_count) > MAX_NODES) ? END_W'(MAX_NODES) : r_node_count;

    // smallest hub edge above the last chosen key
    always_comb begin
        w_hub_b  = w_lb + END_W'(1);
        w_hub_ok = 1'b0;
        if (!r_have_last || (w_lc < w_hc)) begin
            w_hub_b  = END_W'(1);
            w_hub_ok = (r_n != '0);
        end else if ((w_lc == w_hc) && (w_la == '0) && (w_lb < r_n)) begin
            w_hub_ok = 1'b1;
        end
    end

    // road word from the store, filtered and compared
    logic [END_W-1:0]     w_ra, w_rb;
    logic [KW-1:0]        w_rk;
    logic                 w_rk_ok;

    assign w_ra = w_e_rd[EW-1 -: END_W];
    assign w_rb = w_e_rd[EW-END_W-1 -: END_W];
    assign w_rk = {w_e_rd[COST_BITS-1:0], w_ra, w_rb};
    assign w_rk_ok = (w_ra != '0) && (w_ra <= r_n) && (w_rb != '0) && (w_rb <= r_n) &&
                     (!r_have_last || (w_rk > r_last)) && (!r_best_ok || (w_rk < r_best));

    logic w_hit;
    assign w_hit = (w_p_par == r_x);

    // compute datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_CFG_W'(1);
            r_hub_cost   <= '0;
            r_fill       <= '0;
            r_drop       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_have_last  <= 1'b0;
            r_best_ok    <= 1'b0;
            r_rv         <= 1'b0;
            r_side       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NODE_COUNT) r_node_count <= i_cfg_data[NODE_CFG_W-1:0];
                if (i_cfg_index == CFG_HUB_COST) r_hub_cost <= i_cfg_data[IN_COST_W-1:0];
            end
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                DP_LOAD: begin
                    if (w_e_we) r_fill <= r_fill + FW'(1);
                    else r_drop <= 1'b1;
                end
                DP_START: begin
                    r_n         <= w_n_clamp;
                    r_ic        <= '0;
                    r_have_last <= 1'b0;
                    r_sum       <= '0;
                    r_hub       <= '0;
                end
                DP_INIT: begin
                    r_ic <= r_ic + PAW'(1);
                end
                DP_SETUP: begin
                    r_best    <= {w_hc, END_W'(0), w_hub_b};
                    r_best_ok <= w_hub_ok;
                    r_sa      <= '0;
                    r_rv      <= 1'b0;
                end
                DP_SCAN: begin
                    r_rv <= (r_sa < r_fill);
                    if (r_sa < r_fill) r_sa <= r_sa + FW'(1);
                    if (r_rv && w_rk_ok) begin
                        r_best    <= w_rk;
                        r_best_ok <= 1'b1;
                    end
                end
                DP_PICK: begin
                    r_last      <= r_best;
                    r_have_last <= r_best_ok;
                    r_x         <= PAW'(r_best[2*END_W-1 -: END_W]);
                    r_side      <= 1'b0;
                end
                DP_WCHK: begin
                    if (!w_hit) begin
                        r_x <= w_p_par;
                    end else if (!r_side) begin
                        r_ra   <= r_x;
                        r_rka  <= w_p_rank;
                        r_side <= 1'b1;
                        r_x    <= PAW'(r_last[END_W-1:0]);
                    end else begin
                        r_rkb <= w_p_rank;
                        if (r_ra != r_x) begin
                            r_sum <= r_sum + SUM_W'(w_lc);
                            if (w_la == '0) r_hub <= r_hub + HUB_W'(1);
                        end
                    end
                end
                DP_FIN: begin
                    r_out_valid <= 1'b1;
                    r_out_cost  <= r_sum;
                    r_out_hub   <= r_hub;
                    r_out_ovf   <= r_drop;
                    r_fill      <= '0;
                    r_drop      <= 1'b0;
                end
                default: r_rv <= r_rv;
            endcase
        end
    end

    // status to the controller
    assign o_status.init_done = (32'(r_ic) == MAX_NODES);
    assign o_status.scan_done = (r_sa == r_fill) && !r_rv;
    assign o_status.best_ok   = r_best_ok;
    assign o_status.walk_hit  = w_hit;
    assign o_status.walk_side = r_side;
    assign o_status.roots_eq  = (r_ra == r_x);
    assign o_status.need_bump = !w_rank_gt && (r_rka == r_rkb) && (r_rkb != RANK_MAX);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_total_cost     = r_out_cost;
    assign o_hub_edges_used = r_out_hub;
    assign o_overflow       = r_out_ovf;

    `MVH_ASSERT_NXT(a_drop_full, (i_cmd.op == DP_LOAD) && (32'(r_fill) == MAX_ROADS), r_drop, "full store did not flag drop")
    `MVH_ASSERT_NXT(a_fin_clear, i_cmd.op == DP_FIN, (r_fill == '0) && r_out_valid, "finish did not clear store")
    `MVH_ASSERT_NXT(a_pick_last, (i_cmd.op == DP_PICK) && r_best_ok, r_have_last && (r_last == $past(r_best)), "picked key not kept")
endmodule

[design/mst_with_virtual_hub_cost.sv]
// Load word: accepted with no result; loads may follow back to back.
// Compute word: after the accept, the set table is swept entry by entry, then per candidate key
// one setup, a scan of the store, one pick, a read and a check per node on both parent chains
// and up to two join writes; a last empty search ends it. The result is registered once the
// output is free, valid the next cycle.
// Reset (synchronous, active low): fill, drop flag, result valid cleared; node_count 1, hub_cost 0.
module mst_with_virtual_hub_cost #(
    parameter int MAX_NODES = 256,
    parameter int MAX_ROADS = 1024,
    parameter int COST_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mvh_in_if.sink   i_in,
    mvh_out_if.source o_out,
    mvh_cfg_if.sink  i_cfg
);
    import mvh_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    mvh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    mvh_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_ROADS (MAX_ROADS),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_end_a          (i_in.end_a),
        .i_end_b          (i_in.end_b),
        .i_edge_cost      (i_in.edge_cost),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_total_cost     (o_out.total_cost),
        .o_hub_edges_used (o_out.hub_edges_used),
        .o_overflow       (o_out.overflow)
    );
endmodule

[dv/mst_with_virtual_hub_cost_tb.sv]
module mst_with_virtual_hub_cost_tb;
    import mvh_pkg::*;

    localparam int NODES_MAX = 256;
    localparam int ROADS_MAX = 1024;
    localparam int SLOTS     = NODES_MAX + 1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [8:0]  end_a;
        logic [8:0]  end_b;
        logic [15:0] edge_cost;
    } road_word_t;

    typedef struct packed {
        logic [23:0] total_cost;
        logic [8:0]  hub_edges_used;
        logic        overflow;
    } span_word_t;

    logic i_clk;
    logic i_rst_n;

    mvh_in_if  in_ch ();
    mvh_out_if out_ch ();
    mvh_cfg_if cfg_ch ();

    mst_with_virtual_hub_cost dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // mirror of the block's state
    logic [8:0]  nodes_set;
    logic [15:0] hub_fee;
    road_word_t  road_list[$];
    logic        road_lost;
    int          chain_up[SLOTS];
    int          chain_rank[SLOTS];

    road_word_t  pending_words[$];
    span_word_t  span_expected[$];
    int          sent_count;
    bit          failed;
    bit          no_idle;
    bit          drain_hold;
    bit          in_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int set_root(int x);
        int guard;
        guard = 0;
        while (chain_up[x] != x && guard < SLOTS) begin
            x = chain_up[x];
            guard++;
        end
        return x;
    endfunction

    // Kruskal over hub plus stored roads; keys sorted by (cost, a, b)
    function automatic span_word_t span_predict();
        span_word_t     r;
        longint unsigned keys[$];
        int             n, x, y, a, b;
        longint unsigned c;
        logic [23:0]    sum;
        logic [8:0]     hubs;
        n = nodes_set > NODES_MAX ? NODES_MAX : nodes_set;
        for (int i = 0; i < SLOTS; i++) begin
            chain_up[i] = i;
            chain_rank[i] = 0;
        end
        for (int i = 1; i <= n; i++)
            keys = {keys, (longint'(hub_fee) << 26) | longint'(i)};
        foreach (road_list[i]) begin
            a = road_list[i].end_a;
            b = road_list[i].end_b;
            if (a < 1 || a > n || b < 1 || b > n) continue;
            keys = {keys, (longint'(road_list[i].edge_cost) << 26) |
                          (longint'(a) << 13) | longint'(b)};
        end
        keys.sort();
        sum = '0;
        hubs = '0;
        foreach (keys[k]) begin
            a = int'((keys[k] >> 13) & 13'h1fff);
            b = int'(keys[k] & 13'h1fff);
            c = keys[k] >> 26;
            x = set_root(a);
            y = set_root(b);
            if (x != y) begin
                sum = sum + c[23:0];
                if (a == 0) hubs = hubs + 9'd1;
                if (chain_rank[x] > chain_rank[y]) chain_up[y] = x;
                else begin
                    chain_up[x] = y;
                    if (chain_rank[x] == chain_rank[y] && chain_rank[y] < 15)
                        chain_rank[y]++;
                end
            end
        end
        r.total_cost = sum;
        r.hub_edges_used = hubs;
        r.overflow = road_lost;
        road_list.delete();
        road_lost = 1'b0;
        return r;
    endfunction

    // driver: one word per handshake, held until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else if (pending_words.size() > 0 && !drain_hold &&
                     (no_idle || $urandom_range(99) >= 13)) begin
            {in_ch.action, in_ch.end_a, in_ch.end_b, in_ch.edge_cost} <= pending_words.pop_front();
            in_ch.valid <= 1'b1;
        end else begin
            in_ch.valid <= 1'b0;
        end
        out_ch.ready <= no_idle || $urandom_range(99) >= 13;
    end

    // accept monitor: predict on accepted input
    always @(posedge i_clk) begin
        road_word_t w;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            w = {in_ch.action, in_ch.end_a, in_ch.end_b, in_ch.edge_cost};
            sent_count++;
            if (w.action == ACT_LOAD) begin
                if (road_list.size() < ROADS_MAX) road_list = {road_list, w};
                else road_lost = 1'b1;
            end else begin
                span_expected = {span_expected, span_predict()};
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        span_word_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.total_cost, out_ch.hub_edges_used, out_ch.overflow};
            if (span_expected.size() == 0) begin
                $display("%0t unexpected word %h", $time, got);
                failed = 1'b1;
            end else begin
                want = span_expected.pop_front();
                if (got.total_cost !== want.total_cost) begin
                    $display("%0t total_cost exp %0d got %0d", $time,
                             want.total_cost, got.total_cost);
                    failed = 1'b1;
                end
                if (got.hub_edges_used !== want.hub_edges_used) begin
                    $display("%0t hub_edges_used exp %0d got %0d", $time,
                             want.hub_edges_used, got.hub_edges_used);
                    failed = 1'b1;
                end
                if (got.overflow !== want.overflow) begin
                    $display("%0t overflow exp %0d got %0d", $time,
                             want.overflow, got.overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic push_road(int a, int b, int c);
        road_word_t w;
        w.action = ACT_LOAD;
        w.end_a = a[8:0];
        w.end_b = b[8:0];
        w.edge_cost = c[15:0];
        pending_words = {pending_words, w};
    endtask

    task automatic push_compute();
        road_word_t w;
        w = '0;
        w.action = ACT_COMPUTE;
        w.end_a = $urandom;
        w.end_b = $urandom;
        w.edge_cost = $urandom;
        pending_words = {pending_words, w};
    endtask

    // wait until every queued word went in and every result came back
    task automatic drain();
        while (pending_words.size() > 0 || in_ch.valid || span_expected.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[15:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_NODE_COUNT) nodes_set = val[8:0];
        else hub_fee = val[15:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one graph: mostly in-range roads, some noise ends
    task automatic push_graph(int roads, int n, int cmax);
        for (int i = 0; i < roads; i++) begin
            if ($urandom_range(9) == 0)
                push_road($urandom_range(511), $urandom_range(511), $urandom);
            else
                push_road($urandom_range(1, n), $urandom_range(1, n), $urandom_range(cmax));
        end
        push_compute();
    endtask

    initial begin
        int n;
        failed = 1'b0;
        sent_count = 0;
        no_idle = 1'b0;
        drain_hold = 1'b0;
        in_taken = 1'b0;
        nodes_set = 9'd1;
        hub_fee = '0;
        road_lost = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.end_a = '0;
        in_ch.end_b = '0;
        in_ch.edge_cost = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_NODE_COUNT;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: one node, free hub
        push_road(1, 1, 5);
        push_compute();
        drain();

        // small graph with hub ties, self loop, out of range ends
        write_reg(CFG_NODE_COUNT, 4);
        write_reg(CFG_HUB_COST, 10);
        push_road(1, 2, 10);
        push_road(2, 3, 3);
        push_road(3, 3, 0);
        push_road(0, 1, 1);
        push_road(4, 5, 1);
        push_road(256, 511, 65535);
        push_road(3, 4, 65535);
        push_compute();
        push_compute();
        drain();

        // node count zero, then beyond the limit, max hub cost
        write_reg(CFG_NODE_COUNT, 0);
        push_road(1, 2, 7);
        push_compute();
        drain();
        write_reg(CFG_NODE_COUNT, 511);
        write_reg(CFG_HUB_COST, 65535);
        push_road(256, 1, 0);
        push_road(255, 256, 65535);
        push_compute();
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            n = (ph == 5) ? 256 : $urandom_range(1, 20);
            write_reg(CFG_NODE_COUNT, n);
            write_reg(CFG_HUB_COST, (ph % 4 == 0) ? 65535 : $urandom_range(0, 300));
            no_idle = (ph == 3);
            for (int g = 0; g < 6; g++)
                push_graph($urandom_range(0, 16), n, (g % 2) ? 300 : 65535);
            if (ph == 7) begin
                while (pending_words.size() > 0 || in_ch.valid) @(posedge i_clk);
                drain_hold = 1'b1;
                while (span_expected.size() > 0) @(posedge i_clk);
                drain_hold = 1'b0;
            end
            drain();
        end
        no_idle = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (!failed && span_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/mvh_pkg.sv
design/mvh_if.sv
design/mvh_ram.sv
design/mvh_ctrl.sv
design/mvh_dp.sv
design/mst_with_virtual_hub_cost.sv
dv/mst_with_virtual_hub_cost_tb.sv
